### hw/rtl/erdd_pkg.sv
`timescale 1ns / 1ps

package erdd_pkg;

  localparam int MAX_WIDTH_DEF = 1024;

  localparam int PIX_W = 16;
  localparam int DITH_W = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W = 1;
  localparam int IMG_WIDTH_W = 11;
  localparam int IMG_HEIGHT_W = 16;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

  localparam logic [IMG_WIDTH_W-1:0] IMAGE_WIDTH_RST = 11'd640;
  localparam logic [IMG_HEIGHT_W-1:0] IMAGE_HEIGHT_RST = 16'd480;

  localparam logic signed [PIX_W-1:0] THRESHOLD = 16'sd128;
  localparam logic [DITH_W-1:0] DITH_HIGH = 8'd255;
  localparam logic [DITH_W-1:0] DITH_LOW = 8'd0;

  localparam logic [2:0] WT_RIGHT = 3'd7;
  localparam logic [2:0] WT_DOWN_LEFT = 3'd3;
  localparam logic [2:0] WT_DOWN = 3'd5;
  localparam logic [2:0] WT_DOWN_RIGHT = 3'd1;

  // Depth of the result queue: one item in the compute stage plus two waiting.
  localparam int OUTQ_DEPTH = 3;
  localparam int OUTQ_CNT_W = 2;

  typedef struct packed {
    logic vld;
    logic [DITH_W-1:0] pix;
  } erdd_res_t;

  // Share of an error: weight * err / 16, truncated toward zero, kept to 16 bits.
  function automatic logic [PIX_W-1:0] err_share(input logic signed [PIX_W-1:0] err,
                                                 input logic [2:0] wt);
    logic signed [19:0] e;
    logic signed [19:0] w;
    logic signed [19:0] p;
    logic signed [19:0] b;
    logic signed [19:0] q;
    e = 20'(err);
    w = {17'd0, wt};
    p = e * w;
    b = p + (p[19] ? 20'sd15 : 20'sd0);
    q = b >>> 4;
    return q[PIX_W-1:0];
  endfunction

endpackage

### hw/rtl/erdd_pix_if.sv
`timescale 1ns / 1ps

interface erdd_pix_if;
  logic valid;
  logic ready;
  logic [erdd_pkg::PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

### hw/rtl/erdd_dith_if.sv
`timescale 1ns / 1ps

interface erdd_dith_if;
  logic valid;
  logic ready;
  logic [erdd_pkg::DITH_W-1:0] dithered_pixel;

  modport source (output valid, output dithered_pixel, input ready);
  modport sink (input valid, input dithered_pixel, output ready);
endinterface

### hw/rtl/erdd_outq.sv
`timescale 1ns / 1ps

module erdd_outq (
  input  logic                                clk,
  input  logic                                rst_n,
  input  erdd_pkg::erdd_res_t                 push,
  output logic [erdd_pkg::OUTQ_CNT_W-1:0]     count,
  erdd_dith_if.source                         out_chan
);

  localparam int DEPTH = erdd_pkg::OUTQ_DEPTH;
  localparam int PW = erdd_pkg::OUTQ_CNT_W;

  logic [erdd_pkg::DITH_W-1:0] entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0] cnt_r, cnt_nxt;
  logic pop;

  assign pop = out_chan.valid && out_chan.ready;
  assign out_chan.valid = (cnt_r != '0);
  assign out_chan.dithered_pixel = entry_r[rd_ptr_r];
  assign count = cnt_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt = cnt_r;
    if (push.vld) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push.vld && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push.vld && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld) begin
      entry_r[wr_ptr_r] <= push.pix;
    end
  end

endmodule

### hw/rtl/error_diffusion_dither_top.sv
`timescale 1ns / 1ps
// A pixel beat is registered in the compute stage, then its result in the result queue.
// Throughput: one pixel per cycle while in_chan.ready is high, held by the right-neighbor
// error loop in the compute stage; a three-entry result queue lets input continue while
// output waits. Reset (synchronous, rst_n low) restores 640 x 480 and clears all error
// state; the row error memory is then zeroed one entry per cycle with in_chan.ready low.

module error_diffusion_dither_top #(
  parameter int MAX_WIDTH = erdd_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [erdd_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [erdd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  erdd_pix_if.sink                            in_chan,
  erdd_dith_if.source                         out_chan
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int PW = erdd_pkg::PIX_W;

  // Configuration
  logic [erdd_pkg::IMG_WIDTH_W-1:0] width_r;
  logic [erdd_pkg::IMG_HEIGHT_W-1:0] height_r;
  logic [WW-1:0] w_eff;
  logic [erdd_pkg::IMG_HEIGHT_W-1:0] h_eff;

  // Accept side: frame position
  logic [CW-1:0] col_cnt_r;
  logic [15:0] row_cnt_r;
  logic acc_last_col, acc_last_row;
  logic in_accept;

  // Clearing pass
  logic clr_r;
  logic [CW-1:0] clr_addr_r;

  // Row error memory
  logic [PW-1:0] err_mem [MAX_WIDTH];
  logic [PW-1:0] mem_q_r;
  logic mem_we;
  logic [CW-1:0] mem_waddr;
  logic [PW-1:0] mem_wdata;
  logic fwd_hit_r;
  logic [PW-1:0] fwd_data_r;

  // Compute stage
  logic s1_v_r;
  logic [PW-1:0] s1_pix_r;
  logic [CW-1:0] s1_col_r;
  logic s1_last_col_r, s1_last_row_r;
  logic [PW-1:0] rec_r, rec_nxt;
  logic [PW-1:0] pbl_r, pbl_nxt;
  logic [PW-1:0] pb_r, pb_nxt;
  logic def_v_r;
  logic [CW-1:0] def_addr_r;
  logic [PW-1:0] def_data_r;
  logic [PW-1:0] pbl_sum;
  logic dir_we;
  logic [CW-1:0] dir_addr;
  logic [PW-1:0] dir_data;
  logic [erdd_pkg::DITH_W-1:0] s1_out;

  erdd_pkg::erdd_res_t res;
  logic [erdd_pkg::OUTQ_CNT_W-1:0] q_cnt;

  always_comb begin
    if (width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
    h_eff = (height_r == '0) ? 16'd1 : height_r;
  end

  assign acc_last_col = (32'(col_cnt_r) + 32'd1) >= 32'(w_eff);
  assign acc_last_row = ({1'b0, row_cnt_r} + 17'd1) >= {1'b0, h_eff};

  // The queue must have room for the item in the compute stage and this one.
  assign in_chan.ready = !clr_r &&
                         (({1'b0, q_cnt} + {2'b00, s1_v_r}) <= 3'd2);
  assign in_accept = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= erdd_pkg::IMAGE_WIDTH_RST;
      height_r <= erdd_pkg::IMAGE_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        erdd_pkg::CFG_IMAGE_WIDTH: begin
          width_r <= cfg_wdata[erdd_pkg::IMG_WIDTH_W-1:0];
        end
        erdd_pkg::CFG_IMAGE_HEIGHT: begin
          height_r <= cfg_wdata[erdd_pkg::IMG_HEIGHT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      clr_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      if (clr_r && (clr_addr_r == CW'(MAX_WIDTH - 1))) begin
        clr_r <= 1'b0;
      end
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (in_accept) begin
        if (acc_last_col) begin
          col_cnt_r <= '0;
          row_cnt_r <= acc_last_row ? 16'd0 : row_cnt_r + 16'd1;
        end else begin
          col_cnt_r <= col_cnt_r + 1'b1;
        end
      end
    end
  end

  // Write port: clearing pass, the down-left update of the current item, or the
  // end-of-row entry left over from the previous item. Never two in one cycle.
  always_comb begin
    if (clr_r) begin
      mem_we = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else if (def_v_r) begin
      mem_we = 1'b1;
      mem_waddr = def_addr_r;
      mem_wdata = def_data_r;
    end else begin
      mem_we = dir_we;
      mem_waddr = dir_addr;
      mem_wdata = dir_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      err_mem[mem_waddr] <= mem_wdata;
    end
    mem_q_r <= err_mem[col_cnt_r];
    // The read returns old data, so catch a write to the same entry in that cycle.
    fwd_hit_r <= mem_we && (mem_waddr == col_cnt_r);
    fwd_data_r <= mem_wdata;
  end

  always_comb begin
    logic [PW-1:0] below;
    logic [PW-1:0] v;
    logic signed [PW-1:0] err;
    logic [PW-1:0] s7, s3, s5, s1;
    if (def_v_r && (def_addr_r == s1_col_r)) begin
      below = def_data_r;
    end else if (fwd_hit_r) begin
      below = fwd_data_r;
    end else begin
      below = mem_q_r;
    end
    v = s1_pix_r + rec_r + below;
    s1_out = ($signed(v) < erdd_pkg::THRESHOLD) ? erdd_pkg::DITH_LOW : erdd_pkg::DITH_HIGH;
    err = $signed(v - {8'd0, s1_out});
    s7 = erdd_pkg::err_share(err, erdd_pkg::WT_RIGHT);
    s3 = erdd_pkg::err_share(err, erdd_pkg::WT_DOWN_LEFT);
    s5 = erdd_pkg::err_share(err, erdd_pkg::WT_DOWN);
    s1 = erdd_pkg::err_share(err, erdd_pkg::WT_DOWN_RIGHT);
    if (s1_last_row_r) begin
      s3 = '0;
      s5 = '0;
      s1 = '0;
    end
    if (s1_last_col_r) begin
      s7 = '0;
      s1 = '0;
    end
    dir_we = s1_v_r && (s1_col_r != '0);
    dir_addr = s1_col_r - 1'b1;
    dir_data = pbl_r + s3;
    pbl_sum = pb_r + s5;
    if (s1_last_col_r) begin
      pbl_nxt = '0;
      pb_nxt = '0;
      rec_nxt = '0;
    end else begin
      pbl_nxt = pbl_sum;
      pb_nxt = s1;
      rec_nxt = s7;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      def_v_r <= 1'b0;
      rec_r <= '0;
      pbl_r <= '0;
      pb_r <= '0;
    end else begin
      s1_v_r <= in_accept;
      def_v_r <= s1_v_r && s1_last_col_r;
      if (s1_v_r) begin
        rec_r <= rec_nxt;
        pbl_r <= pbl_nxt;
        pb_r <= pb_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pix_r <= in_chan.pixel_value;
      s1_col_r <= col_cnt_r;
      s1_last_col_r <= acc_last_col;
      s1_last_row_r <= acc_last_row;
    end
    def_addr_r <= s1_col_r;
    def_data_r <= pbl_sum;
  end

  assign res.vld = s1_v_r;
  assign res.pix = s1_out;

  erdd_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res),
    .count    (q_cnt),
    .out_chan (out_chan)
  );

endmodule

### hw/rtl/erdd_checker.sv
`timescale 1ns / 1ps

module erdd_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [erdd_pkg::DITH_W-1:0]       out_data
);

  logic [2:0] pend_r;
  logic in_beat, out_beat;

  assign in_beat = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {2'b00, in_beat} - {2'b00, out_beat};
    end
  end

  // The memory clearing pass keeps input closed right after reset.
  a_ready_after_reset: assert property (@(posedge clk) $past(!rst_n) |-> !in_ready)
    else $error("input ready right after reset");

  // Every result beat is a pixel that was accepted earlier.
  a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat |-> (pend_r != 3'd0))
    else $error("result beat without a pending pixel");

  // Pixels in flight never exceed the result queue depth of three.
  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd3)
    else $error("too many pixels in flight");

  // A dithered pixel is black or white.
  a_binary_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data == erdd_pkg::DITH_LOW || out_data == erdd_pkg::DITH_HIGH))
    else $error("dithered pixel is neither 0 nor 255");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

endmodule

bind error_diffusion_dither_top erdd_checker u_erdd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.dithered_pixel)
);

### tb/sv/erdd_dither_check.sv
`timescale 1ns / 1ps

module erdd_dither_check (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [erdd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [erdd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            pix_valid,
  input  logic                            pix_ready,
  input  logic [erdd_pkg::PIX_W-1:0]      pix_value,
  input  logic                            dith_valid,
  input  logic                            dith_ready,
  input  logic [erdd_pkg::DITH_W-1:0]     dith_value,
  output int                              mismatch_count,
  output int                              owed_count
);
  import erdd_pkg::*;

  localparam int MAX_COLS = MAX_WIDTH_DEF;

  logic [IMG_WIDTH_W-1:0]  width_reg;
  logic [IMG_HEIGHT_W-1:0] height_reg;
  logic [PIX_W-1:0]        row_err [MAX_COLS];
  logic [PIX_W-1:0]        carry_right;
  logic [PIX_W-1:0]        below_left;
  logic [PIX_W-1:0]        below_here;
  int unsigned             col_pos;
  int unsigned             row_pos;
  logic [DITH_W-1:0]       dith_expected [$];

  function automatic logic [PIX_W-1:0] weighted_share(input int err, input int wt);
    int s;
    s = (wt * err) / 16;
    return s[PIX_W-1:0];
  endfunction

  // Quantizes one pixel and moves the error state on, exactly as the block must.
  function automatic logic [DITH_W-1:0] dither_pixel(input logic [PIX_W-1:0] pv);
    int unsigned      w;
    int unsigned      h;
    int unsigned      col;
    logic             last_col;
    logic             last_row;
    logic [PIX_W-1:0] v;
    logic [PIX_W-1:0] e16;
    logic [PIX_W-1:0] s7;
    logic [PIX_W-1:0] s3;
    logic [PIX_W-1:0] s5;
    logic [PIX_W-1:0] s1;
    int               err;
    logic [DITH_W-1:0] q;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > MAX_COLS) w = MAX_COLS;
    h = height_reg;
    if (h == 0) h = 1;
    col = col_pos;
    if (col >= MAX_COLS) col = MAX_COLS - 1;
    // A position at or past a shrunken frame counts as its last column or row.
    last_col = (col + 1 >= w);
    last_row = (row_pos + 1 >= h);

    v = pv + carry_right + row_err[col];
    q = ($signed(v) < THRESHOLD) ? DITH_LOW : DITH_HIGH;
    e16 = v - PIX_W'(q);
    err = $signed(e16);

    s7 = weighted_share(err, WT_RIGHT);
    s3 = weighted_share(err, WT_DOWN_LEFT);
    s5 = weighted_share(err, WT_DOWN);
    s1 = weighted_share(err, WT_DOWN_RIGHT);
    if (last_row) begin
      s3 = '0;
      s5 = '0;
      s1 = '0;
    end
    if (last_col) begin
      s7 = '0;
      s1 = '0;
    end

    if (col >= 1) row_err[col-1] = below_left + s3;
    below_left = below_here + s5;
    below_here = s1;
    carry_right = s7;

    if (last_col) begin
      row_err[col] = below_left;
      below_left = '0;
      below_here = '0;
      carry_right = '0;
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos = col + 1;
    end
    return q;
  endfunction

  always @(posedge clk) begin
    logic [DITH_W-1:0] want;
    if (!rst_n) begin
      width_reg = IMAGE_WIDTH_RST;
      height_reg = IMAGE_HEIGHT_RST;
      foreach (row_err[i]) row_err[i] = '0;
      carry_right = '0;
      below_left = '0;
      below_here = '0;
      col_pos = 0;
      row_pos = 0;
      dith_expected.delete();
      mismatch_count = 0;
    end else begin
      if (dith_valid && dith_ready) begin
        if (dith_expected.size() == 0) begin
          $error("dithered_pixel: no beat expected, actual %0d", dith_value);
          mismatch_count++;
        end else begin
          want = dith_expected.pop_front();
          if (dith_value !== want) begin
            $error("dithered_pixel: expected %0d, actual %0d", want, dith_value);
            mismatch_count++;
          end
        end
      end
      if (pix_valid && pix_ready) dith_expected.push_back(dither_pixel(pix_value));
      if (cfg_we) begin
        case (cfg_idx)
          CFG_IMAGE_WIDTH: width_reg = cfg_wdata[IMG_WIDTH_W-1:0];
          CFG_IMAGE_HEIGHT: height_reg = cfg_wdata[IMG_HEIGHT_W-1:0];
          default: ;
        endcase
      end
    end
    owed_count = dith_expected.size();
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import erdd_pkg::*;

  localparam int CLK_PERIOD = 8;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 450;
  localparam int SETTLE_CYCLES = 4;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  erdd_pix_if pix ();
  erdd_dith_if dith ();

  int mismatch_count;
  int owed_count;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;
  bit input_burst = 1'b0;
  bit output_steady = 1'b0;

  logic [PIX_W-1:0] corner_pixels [12] = '{
    16'h7FFF, 16'h8000, 16'h0000, 16'h007F, 16'h0080, 16'hFFFF,
    16'h00FF, 16'h0100, 16'h7F80, 16'h807F, 16'h00C8, 16'h003C
  };

  always #(CLK_PERIOD / 2) clk = ~clk;

  error_diffusion_dither_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_chan   (pix),
    .out_chan  (dith)
  );

  erdd_dither_check dither_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .pix_valid      (pix.valid),
    .pix_ready      (pix.ready),
    .pix_value      (pix.pixel_value),
    .dith_valid     (dith.valid),
    .dith_ready     (dith.ready),
    .dith_value     (dith.dithered_pixel),
    .mismatch_count (mismatch_count),
    .owed_count     (owed_count)
  );

  // In a burst no gap; else mostly none, sometimes short, now and then long.
  function automatic int pick_gap(input bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [PIX_W-1:0] random_pixel();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return PIX_W'($urandom_range(0, 255));
    if (r < 7) return PIX_W'($urandom());
    if (r == 7) begin
      if ($urandom_range(0, 1)) return 16'h7FFF - PIX_W'($urandom_range(0, 300));
      return 16'h8000 + PIX_W'($urandom_range(0, 300));
    end
    if (r == 8) return PIX_W'($urandom_range(96, 160));
    return PIX_W'(int'($urandom_range(0, 1023)) - 512);
  endfunction

  // Entered at a falling edge; returns at the falling edge after the beat with
  // valid still high, so a following call can present the next pixel at once.
  task automatic push_pixel(input logic [PIX_W-1:0] pv);
    int gap;
    gap = pick_gap(input_burst);
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix.valid <= 1'b1;
    pix.pixel_value <= pv;
    do @(posedge clk); while (!pix.ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    pix.valid <= 1'b0;
    while (owed_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_frame(input int w, input int h);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
  endtask

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("tb: errors");
    $finish;
  end

  initial begin
    int stall_left;
    stall_left = 0;
    dith.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        dith.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else if (stall_left > 0) begin
        dith.ready <= 1'b0;
        stall_left--;
      end else begin
        dith.ready <= 1'b1;
        if ($urandom_range(0, 149) == 0) output_steady = !output_steady;
        stall_left = pick_gap(output_steady);
      end
    end
  end

  initial begin
    int random_sent;
    int n;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_IMAGE_WIDTH;
    cfg_wdata = '0;
    pix.valid = 1'b0;
    pix.pixel_value = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // The row store is cleared after reset; input is held off until then.
    while (!pix.ready) @(negedge clk);

    // Reset frame size, then shrink it so the column is already past the edge.
    repeat (5) push_pixel(random_pixel());
    drain_results();
    set_frame(4, 3);
    foreach (corner_pixels[i]) push_pixel(corner_pixels[i]);
    drain_results();
    set_frame(0, 0);
    repeat (3) push_pixel(random_pixel());
    drain_results();
    set_frame(2047, 2);
    repeat (3) push_pixel(16'h8000);
    drain_results();
    set_frame(1, 65535);
    repeat (2) push_pixel(16'h7FFF);
    drain_results();

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: write_reg(CFG_IMAGE_WIDTH, $urandom_range(1, 16));
        1: write_reg(CFG_IMAGE_HEIGHT, $urandom_range(1, 8));
        2: set_frame($urandom_range(0, 1), $urandom_range(1, 6));
        3: set_frame($urandom_range(1, 10), $urandom_range(0, 1) ? 0 : 65535);
        4: set_frame($urandom_range(17, 64), $urandom_range(1, 4));
        default: set_frame($urandom_range(1, 12), $urandom_range(1, 6));
      endcase
      input_burst = ($urandom_range(0, 4) == 0);
      n = $urandom_range(1, 100);
      repeat (n) push_pixel(random_pixel());
      random_sent += n;
      drain_results();
    end

    // One full-width row and a bit of the next, with the output held off for a
    // long stretch while pixels keep being offered.
    set_frame(MAX_WIDTH_DEF, 2);
    input_burst = 1'b1;
    hold_request = 1'b1;
    repeat (MAX_WIDTH_DEF + 40) push_pixel(random_pixel());
    drain_results();

    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && owed_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/erdd_pkg.sv
hw/rtl/erdd_pix_if.sv
hw/rtl/erdd_dith_if.sv
hw/rtl/erdd_outq.sv
hw/rtl/error_diffusion_dither_top.sv
hw/rtl/erdd_checker.sv
tb/sv/erdd_dither_check.sv
tb/sv/tb.sv
